// ===== hw/rtl/otq_pkg.sv =====
// Package for the ordered timer queue: codes, state types and the slot entry layout.
package otq_pkg;

   localparam int DefaultMaxTimers = 16;
   localparam int MaxResults       = 16;
   localparam logic [31:0] RolloverReset = 32'd3600000;

   localparam int ReqDataW = 104;
   localparam int RspDataW = 72;

   localparam logic [2:0] OP_ADD     = 3'd0;
   localparam logic [2:0] OP_CANCEL  = 3'd1;
   localparam logic [2:0] OP_REFRESH = 3'd2;
   localparam logic [2:0] OP_RESET   = 3'd3;
   localparam logic [2:0] OP_COLLECT = 3'd4;
   localparam logic [2:0] OP_QUERY   = 3'd5;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_REFUSED = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_EVAL,
      S_CALC,
      S_SCAN,
      S_WAIT,
      S_PICKED,
      S_EMIT
   } state_type;

   typedef enum logic [2:0] {
      K_ADD,
      K_FRONT,
      K_QUERY,
      K_DUE,
      K_PICK
   } scan_type;

   typedef struct packed {
      logic        rec;
      logic [31:0] per;
      logic [63:0] dl;
   } entry_type;

endpackage

// ===== hw/rtl/ordered_timer_queue.sv =====
// Top level of the ordered timer queue: slot memory, sweep sequencer and result register.
//
//  channel | direction | beat contents
//  --------+-----------+---------------------------------------------------------------
//  req_    | in        | tuser: req_type; tdata: now_ms, timer_id, period_ms, recurring,
//          |           |   restart_now
//  rsp_    | out       | tuser: expired_valid; tlast: last; tdata: status, result_id,
//          |           |   wait_ms, timers_pending, front_notify
//  csr_    | in        | wdata: rollover_window_ms
//
// One operation is taken at a time. Cancel and unknown codes go from dispatch straight to the
// emit step; refresh, and a reset for a valid slot that is refused or keeps its period, pass
// through the evaluate step first. A reset that moves the deadline also sweeps the slot memory
// once. Add sweeps the slot memory once, one entry a cycle through its single read port; query
// sweeps once and then works out the wait. Collect sweeps once to mark due slots and once more
// per slot that it reports. Reset is synchronous and clears the armed bits, the tickle flag and
// the previous time, and restores the window to its default; the slot memory itself is not
// cleared. A stalled result channel holds the sequencer in its emit step.
module ordered_timer_queue #(
   parameter int MAX_TIMERS = otq_pkg::DefaultMaxTimers
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // tdata, low bit up: now_ms[63:0], timer_id[67:64], period_ms[99:68], recurring[100],
   // restart_now[101], zero fill[103:102]
   input  logic [otq_pkg::ReqDataW-1:0]  req_tdata,
   // tuser: req_type[2:0]
   input  logic [2:0]                    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // tdata, low bit up: status[1:0], result_id[5:2], wait_ms[69:6], timers_pending[70],
   // front_notify[71]
   output logic [otq_pkg::RspDataW-1:0]  rsp_tdata,
   // tuser: expired_valid[0]
   output logic                          rsp_tuser,
   output logic                          rsp_tlast,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [31:0]                   csr_wdata
);
   import otq_pkg::*;

   localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
   localparam logic [IW-1:0] LastSlot = IW'(MAX_TIMERS - 1);

   // Slot memory: recurring mark, period and deadline of each slot.
   entry_type mem [MAX_TIMERS];

   state_type state_ff, state_in;
   scan_type  kind_ff, kind_in;
   logic [2:0]  op_ff, op_in;
   logic [63:0] now_ff, now_in;
   logic [3:0]  id_ff, id_in;
   logic [31:0] per_ff, per_in;
   logic        rec_ff, rec_in;
   logic        fnow_ff, fnow_in;
   logic [63:0] dl_new_ff, dl_new_in;
   logic [63:0] start_ff, start_in;
   logic [MAX_TIMERS-1:0] armed_ff, armed_in;
   logic [MAX_TIMERS-1:0] due_ff, due_in;
   logic        tickled_ff, tickled_in;
   logic [63:0] prev_ff, prev_in;
   logic [31:0] window_ff, window_in;
   logic        roll_ff, roll_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic        iss_done_ff, iss_done_in;
   logic        rd_vld_ff, rd_vld_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   entry_type   rd_ent_ff;
   logic        found_ff, found_in;
   logic        blocked_ff, blocked_in;
   logic [IW-1:0] best_ff, best_in;
   entry_type   best_ent_ff, best_ent_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        stay_ff, stay_in;
   logic [4:0]  target_ff, target_in;
   logic [4:0]  done_ff, done_in;
   logic        coll_pend_ff, coll_pend_in;

   logic [1:0]  res_status_ff, res_status_in;
   logic [3:0]  res_id_ff, res_id_in;
   logic [63:0] res_wait_ff, res_wait_in;
   logic        res_notify_ff, res_notify_in;
   logic        res_valid_ff, res_valid_in;
   logic        res_last_ff, res_last_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0]  rsp_data_ff, rsp_data_in;
   logic                 rsp_user_ff, rsp_user_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   entry_type     mem_wdata;
   logic          rd_en;
   logic [IW-1:0] rd_addr;

   logic          scan_go;
   scan_type      scan_kind;
   logic [IW-1:0] id_slot;
   logic          id_ok;
   logic          sample_last;
   logic          due_now;
   logic          pend;

   assign id_slot   = IW'(id_ff);
   assign id_ok     = {28'd0, id_ff} < 32'(MAX_TIMERS);
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      op_in = op_ff;
      now_in = now_ff;
      id_in = id_ff;
      per_in = per_ff;
      rec_in = rec_ff;
      fnow_in = fnow_ff;
      dl_new_in = dl_new_ff;
      start_in = start_ff;
      armed_in = armed_ff;
      due_in = due_ff;
      tickled_in = tickled_ff;
      prev_in = prev_ff;
      window_in = window_ff;
      roll_in = roll_ff;
      idx_in = idx_ff;
      iss_done_in = iss_done_ff;
      rd_vld_in = 1'b0;
      rd_idx_in = rd_idx_ff;
      found_in = found_ff;
      blocked_in = blocked_ff;
      best_in = best_ff;
      best_ent_in = best_ent_ff;
      cnt_in = cnt_ff;
      stay_in = stay_ff;
      target_in = target_ff;
      done_in = done_ff;
      coll_pend_in = coll_pend_ff;
      res_status_in = res_status_ff;
      res_id_in = res_id_ff;
      res_wait_in = res_wait_ff;
      res_notify_in = res_notify_ff;
      res_valid_in = res_valid_ff;
      res_last_in = res_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_last_in = rsp_last_ff;
      mem_we = 1'b0;
      mem_waddr = id_slot;
      mem_wdata = rd_ent_ff;
      rd_en = 1'b0;
      rd_addr = id_slot;
      scan_go = 1'b0;
      scan_kind = K_ADD;
      sample_last = 1'b0;
      due_now = 1'b0;
      pend = 1'b0;

      if (csr_valid) begin
         window_in = csr_wdata;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in   = req_tuser;
               now_in  = req_tdata[63:0];
               id_in   = req_tdata[67:64];
               per_in  = req_tdata[99:68];
               rec_in  = req_tdata[100];
               fnow_in = req_tdata[101];
               dl_new_in = req_tdata[63:0] + {32'd0, req_tdata[99:68]};
               roll_in = (prev_ff > req_tdata[63:0]) &&
                         ((prev_ff - req_tdata[63:0]) > {32'd0, window_ff});
               state_in = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            // Every result starts as a plain ok beat; each operation overrides what it needs.
            res_status_in = STATUS_OK;
            res_id_in     = '0;
            res_wait_in   = '0;
            res_notify_in = 1'b0;
            res_valid_in  = 1'b0;
            res_last_in   = 1'b1;
            rd_en         = 1'b1;
            state_in      = S_EMIT;
            case (op_ff)
               OP_ADD: begin
                  scan_go = 1'b1;
                  scan_kind = K_ADD;
               end
               OP_CANCEL: begin
                  if (id_ok && armed_ff[id_slot]) begin
                     armed_in[id_slot] = 1'b0;
                  end else begin
                     res_status_in = STATUS_REFUSED;
                  end
               end
               OP_REFRESH: begin
                  if (id_ok && armed_ff[id_slot]) begin
                     state_in = S_EVAL;
                  end else begin
                     res_status_in = STATUS_REFUSED;
                  end
               end
               OP_RESET: begin
                  if (id_ok) begin
                     state_in = S_EVAL;
                  end else begin
                     res_status_in = STATUS_REFUSED;
                  end
               end
               OP_COLLECT: begin
                  if (|armed_ff) begin
                     prev_in = now_ff;
                     scan_go = 1'b1;
                     scan_kind = K_DUE;
                  end else begin
                     coll_pend_in = 1'b0;
                  end
               end
               OP_QUERY: begin
                  tickled_in = 1'b0;
                  scan_go = 1'b1;
                  scan_kind = K_QUERY;
               end
               default: begin
               end
            endcase
         end

         S_EVAL: begin
            state_in = S_EMIT;
            if (op_ff == OP_REFRESH) begin
               mem_we = 1'b1;
               mem_wdata.dl = now_ff + {32'd0, rd_ent_ff.per};
            end else if (per_ff == rd_ent_ff.per && !fnow_ff) begin
               res_status_in = STATUS_OK;
            end else if (!armed_ff[id_slot]) begin
               res_status_in = STATUS_REFUSED;
            end else begin
               start_in = fnow_ff ? now_ff : rd_ent_ff.dl - {32'd0, rd_ent_ff.per};
               best_ent_in = rd_ent_ff;
               state_in = S_CALC;
            end
         end

         S_CALC: begin
            dl_new_in = start_ff + {32'd0, per_ff};
            mem_we = 1'b1;
            mem_wdata.rec = best_ent_ff.rec;
            mem_wdata.per = per_ff;
            mem_wdata.dl  = start_ff + {32'd0, per_ff};
            scan_go = 1'b1;
            scan_kind = K_FRONT;
         end

         S_SCAN: begin
            if (!iss_done_ff) begin
               rd_en = 1'b1;
               rd_addr = idx_ff;
               rd_vld_in = 1'b1;
               rd_idx_in = idx_ff;
               idx_in = idx_ff + 1'b1;
               if (idx_ff == LastSlot) begin
                  iss_done_in = 1'b1;
               end
            end
            if (rd_vld_ff) begin
               sample_last = (rd_idx_ff == LastSlot);
               case (kind_ff)
                  K_ADD: begin
                     // Slots below the first free one win ties against the new slot.
                     if (!armed_ff[rd_idx_ff]) begin
                        if (!found_ff) begin
                           found_in = 1'b1;
                           best_in = rd_idx_ff;
                        end
                     end else if (found_ff ? (rd_ent_ff.dl < dl_new_ff)
                                           : (rd_ent_ff.dl <= dl_new_ff)) begin
                        blocked_in = 1'b1;
                     end
                  end
                  K_FRONT: begin
                     if (armed_ff[rd_idx_ff] && rd_idx_ff != id_slot &&
                         (rd_ent_ff.dl < dl_new_ff ||
                          (rd_ent_ff.dl == dl_new_ff && rd_idx_ff < id_slot))) begin
                        blocked_in = 1'b1;
                     end
                  end
                  K_QUERY: begin
                     if (armed_ff[rd_idx_ff] && (!found_ff || rd_ent_ff.dl < best_ent_ff.dl)) begin
                        found_in = 1'b1;
                        best_ent_in = rd_ent_ff;
                     end
                  end
                  K_DUE: begin
                     due_now = armed_ff[rd_idx_ff] && (roll_ff || rd_ent_ff.dl <= now_ff);
                     due_in[rd_idx_ff] = due_now;
                     if (due_now && cnt_ff <= 5'(MaxResults)) begin
                        cnt_in = cnt_ff + 5'd1;
                     end
                     if (armed_ff[rd_idx_ff] && !(due_now && !rd_ent_ff.rec)) begin
                        stay_in = 1'b1;
                     end
                  end
                  K_PICK: begin
                     if (due_ff[rd_idx_ff] && (!found_ff || rd_ent_ff.dl < best_ent_ff.dl)) begin
                        found_in = 1'b1;
                        best_in = rd_idx_ff;
                        best_ent_in = rd_ent_ff;
                     end
                  end
                  default: begin
                  end
               endcase

               if (sample_last) begin
                  state_in = S_EMIT;
                  case (kind_ff)
                     K_ADD: begin
                        if (!found_in) begin
                           res_status_in = STATUS_FULL;
                        end else begin
                           mem_we = 1'b1;
                           mem_waddr = best_in;
                           mem_wdata.rec = rec_ff;
                           mem_wdata.per = per_ff;
                           mem_wdata.dl  = dl_new_ff;
                           armed_in[best_in] = 1'b1;
                           res_id_in = 4'(best_in);
                           res_notify_in = !blocked_in && !tickled_ff;
                           if (!blocked_in) begin
                              tickled_in = 1'b1;
                           end
                        end
                     end
                     K_FRONT: begin
                        res_notify_in = !blocked_in && !tickled_ff;
                        if (!blocked_in) begin
                           tickled_in = 1'b1;
                        end
                     end
                     K_QUERY: begin
                        state_in = S_WAIT;
                     end
                     K_DUE: begin
                        // Pending after collect is known here: a slot stays armed unless it
                        // is a one-shot among the handled due slots.
                        coll_pend_in = stay_in || (cnt_in > 5'(MaxResults));
                        target_in = (cnt_in > 5'(MaxResults)) ? 5'(MaxResults) : cnt_in;
                        done_in = '0;
                        if (cnt_in != 5'd0) begin
                           scan_go = 1'b1;
                           scan_kind = K_PICK;
                        end
                     end
                     K_PICK: begin
                        state_in = S_PICKED;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end

         S_WAIT: begin
            if (!found_ff) begin
               res_wait_in = '1;
            end else if (now_ff >= best_ent_ff.dl) begin
               res_wait_in = '0;
            end else begin
               res_wait_in = best_ent_ff.dl - now_ff;
            end
            state_in = S_EMIT;
         end

         S_PICKED: begin
            if (best_ent_ff.rec) begin
               mem_we = 1'b1;
               mem_waddr = best_ff;
               mem_wdata.rec = 1'b1;
               mem_wdata.per = best_ent_ff.per;
               mem_wdata.dl  = now_ff + {32'd0, best_ent_ff.per};
            end else begin
               armed_in[best_ff] = 1'b0;
            end
            due_in[best_ff] = 1'b0;
            done_in = done_ff + 5'd1;
            res_status_in = STATUS_OK;
            res_id_in = 4'(best_ff);
            res_valid_in = 1'b1;
            res_last_in = (5'(done_ff + 5'd1) == target_ff);
            state_in = S_EMIT;
         end

         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               pend = (op_ff == OP_COLLECT) ? coll_pend_ff : |armed_ff;
               rsp_valid_in = 1'b1;
               rsp_data_in = {res_notify_ff, pend, res_wait_ff, res_id_ff, res_status_ff};
               rsp_user_in = res_valid_ff;
               rsp_last_in = res_last_ff;
               if (res_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  scan_go = 1'b1;
                  scan_kind = K_PICK;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (scan_go) begin
         state_in = S_SCAN;
         kind_in = scan_kind;
         idx_in = '0;
         iss_done_in = 1'b0;
         rd_vld_in = 1'b0;
         found_in = 1'b0;
         blocked_in = 1'b0;
         cnt_in = '0;
         stay_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         armed_ff     <= '0;
         tickled_ff   <= 1'b0;
         prev_ff      <= '0;
         window_ff    <= RolloverReset;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         armed_ff     <= armed_in;
         tickled_ff   <= tickled_in;
         prev_ff      <= prev_in;
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      op_ff         <= op_in;
      now_ff        <= now_in;
      id_ff         <= id_in;
      per_ff        <= per_in;
      rec_ff        <= rec_in;
      fnow_ff       <= fnow_in;
      dl_new_ff     <= dl_new_in;
      start_ff      <= start_in;
      due_ff        <= due_in;
      roll_ff       <= roll_in;
      idx_ff        <= idx_in;
      iss_done_ff   <= iss_done_in;
      rd_idx_ff     <= rd_idx_in;
      found_ff      <= found_in;
      blocked_ff    <= blocked_in;
      best_ff       <= best_in;
      best_ent_ff   <= best_ent_in;
      cnt_ff        <= cnt_in;
      stay_ff       <= stay_in;
      target_ff     <= target_in;
      done_ff       <= done_in;
      coll_pend_ff  <= coll_pend_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_wait_ff   <= res_wait_in;
      res_notify_ff <= res_notify_in;
      res_valid_ff  <= res_valid_in;
      res_last_ff   <= res_last_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Single write port and single registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_ent_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the ordered timer queue: stimulus, timer table prediction, checks.
`timescale 1ns / 100ps

module testbench;
   import otq_pkg::*;

   // Request codes that the block must pass through without any effect.
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int         NSLOTS      = 16;
   localparam logic [63:0] NO_DEADLINE = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic [2:0]  op;
      logic [63:0] now;
      logic [3:0]  id;
      logic [31:0] period;
      logic        rec;
      logic        fnow;
   } timer_op_type;

   typedef struct {
      logic [1:0]  status;
      logic [3:0]  rid;
      logic [63:0] wait_ms;
      logic        pend;
      logic        notify;
      logic        expv;
      logic        last;
   } timer_rsp_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata  = '0;
   logic [2:0]          req_tuser  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                rsp_tuser;
   logic                rsp_tlast;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [31:0]         csr_wdata  = '0;

   ordered_timer_queue uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Shadow copy of the timer table, updated once per accepted request beat.
   logic        tbl_armed    [NSLOTS];
   logic        tbl_rec      [NSLOTS];
   logic [31:0] tbl_period   [NSLOTS];
   logic [63:0] tbl_deadline [NSLOTS];
   logic        tbl_tickled;
   logic [63:0] tbl_last_collect;
   logic [31:0] tbl_window;

   timer_op_type  op_backlog [$];
   timer_rsp_type rsp_owed   [$];
   timer_op_type  op_on_bus;

   int unsigned ops_issued   = 0;
   int unsigned ops_taken    = 0;
   int unsigned rsp_seen     = 0;
   int unsigned expiries     = 0;
   int unsigned error_count  = 0;
   int unsigned send_gap     = 0;
   int unsigned recv_stall   = 0;
   bit          quiet_bus    = 1'b0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
   endtask

   // Append one request to the tail of the pending list.
   task automatic enqueue_op(input timer_op_type t);
      op_backlog.insert(op_backlog.size(), t);
   endtask

   // True when slot a sorts ahead of slot b: earlier deadline, ties to the lower slot.
   function automatic bit ranks_ahead(input int a, input int b);
      if (tbl_deadline[a] != tbl_deadline[b]) return tbl_deadline[a] < tbl_deadline[b];
      return a < b;
   endfunction

   function automatic bit any_slot_armed();
      foreach (tbl_armed[i]) if (tbl_armed[i]) return 1'b1;
      return 1'b0;
   endfunction

   // A freshly placed slot raises the front notification only if it leads the table
   // and nobody has been told about the front since the last query.
   function automatic bit front_notification(input int s);
      bit lead;
      lead = 1'b1;
      foreach (tbl_armed[i]) if (i != s && tbl_armed[i] && ranks_ahead(i, s)) lead = 1'b0;
      if (lead && !tbl_tickled) begin
         tbl_tickled = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Apply one request to the shadow table and queue the response beats it should produce.
   function automatic void timer_table_step(input timer_op_type t);
      timer_rsp_type outs [$];
      timer_rsp_type r;
      int         slot;
      int         best;
      bit         due [NSLOTS];
      bit         rolled;
      logic [63:0] start;
      r = '{STATUS_OK, 4'd0, 64'd0, 1'b0, 1'b0, 1'b0, 1'b0};
      case (t.op)
         OP_ADD: begin
            slot = -1;
            foreach (tbl_armed[i]) if (slot < 0 && !tbl_armed[i]) slot = i;
            if (slot < 0) begin
               r.status = STATUS_FULL;
            end else begin
               tbl_armed[slot]    = 1'b1;
               tbl_rec[slot]      = t.rec;
               tbl_period[slot]   = t.period;
               tbl_deadline[slot] = t.now + 64'(t.period);
               r.rid    = 4'(slot);
               r.notify = front_notification(slot);
            end
            outs.insert(outs.size(), r);
         end
         OP_CANCEL: begin
            if (tbl_armed[t.id]) tbl_armed[t.id] = 1'b0;
            else r.status = STATUS_REFUSED;
            outs.insert(outs.size(), r);
         end
         OP_REFRESH: begin
            if (tbl_armed[t.id]) tbl_deadline[t.id] = t.now + 64'(tbl_period[t.id]);
            else r.status = STATUS_REFUSED;
            outs.insert(outs.size(), r);
         end
         OP_RESET: begin
            if (t.period == tbl_period[t.id] && !t.fnow) begin
               r.status = STATUS_OK;
            end else if (!tbl_armed[t.id]) begin
               r.status = STATUS_REFUSED;
            end else begin
               start = t.fnow ? t.now : tbl_deadline[t.id] - 64'(tbl_period[t.id]);
               tbl_period[t.id]   = t.period;
               tbl_deadline[t.id] = start + 64'(t.period);
               r.notify = front_notification(t.id);
            end
            outs.insert(outs.size(), r);
         end
         OP_COLLECT: begin
            if (any_slot_armed()) begin
               // A large backward step of the clock expires everything that is armed.
               rolled = tbl_last_collect > t.now &&
                        (tbl_last_collect - t.now) > 64'(tbl_window);
               tbl_last_collect = t.now;
               foreach (due[i]) due[i] = tbl_armed[i] && (rolled || tbl_deadline[i] <= t.now);
               repeat (MaxResults) begin
                  best = -1;
                  foreach (due[i]) if (due[i] && (best < 0 || ranks_ahead(i, best))) best = i;
                  if (best >= 0) begin
                     due[best] = 1'b0;
                     r.rid  = 4'(best);
                     r.expv = 1'b1;
                     outs.insert(outs.size(), r);
                  end
               end
               // Re-arming happens after the order is fixed, so do it in a second pass.
               foreach (outs[k]) begin
                  if (tbl_rec[outs[k].rid])
                     tbl_deadline[outs[k].rid] = t.now + 64'(tbl_period[outs[k].rid]);
                  else
                     tbl_armed[outs[k].rid] = 1'b0;
               end
            end
            if (outs.size() == 0) begin
               r.rid  = 4'd0;
               r.expv = 1'b0;
               outs.insert(outs.size(), r);
            end
         end
         OP_QUERY: begin
            tbl_tickled = 1'b0;
            best = -1;
            foreach (tbl_armed[i]) if (tbl_armed[i] && (best < 0 || ranks_ahead(i, best))) best = i;
            if (best < 0) r.wait_ms = NO_DEADLINE;
            else if (t.now >= tbl_deadline[best]) r.wait_ms = 64'd0;
            else r.wait_ms = tbl_deadline[best] - t.now;
            outs.insert(outs.size(), r);
         end
         default: outs.insert(outs.size(), r);
      endcase
      foreach (outs[k]) begin
         outs[k].pend = any_slot_armed();
         outs[k].last = (k == outs.size() - 1);
         rsp_owed.insert(rsp_owed.size(), outs[k]);
      end
   endfunction

   // Request driver: one beat in flight at a time, random idle bursts between beats.
   always @(negedge clock) begin
      timer_op_type t;
      if (!reset) begin
         if (req_tvalid && ops_taken != ops_issued) begin
            // Beat still waiting for acceptance: hold it.
         end else if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (op_backlog.size() > 0) begin
            if (!quiet_bus && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(1, 19) - 1;
               req_tvalid <= 1'b0;
            end else begin
               t = op_backlog.pop_front();
               op_on_bus = t;
               ops_issued++;
               req_tuser  <= t.op;
               req_tdata  <= {2'b00, t.fnow, t.rec, t.period, t.id, t.now};
               req_tvalid <= 1'b1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response ready: random stall bursts, none once the bus goes quiet.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_tready <= 1'b0;
      end else if (!quiet_bus && $urandom_range(0, 5) == 0) begin
         recv_stall = $urandom_range(1, 19) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predict on every accepted request beat, check every accepted response beat.
   always @(posedge clock) begin
      timer_rsp_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            ops_taken++;
            timer_table_step(op_on_bus);
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            if (rsp_tuser) expiries++;
            if (rsp_owed.size() == 0) begin
               report_mismatch("response beat with nothing outstanding, result_id",
                               64'(rsp_tdata[5:2]), 64'd0);
            end else begin
               want = rsp_owed.pop_front();
               if (rsp_tdata[1:0] !== want.status)
                  report_mismatch("status", 64'(rsp_tdata[1:0]), 64'(want.status));
               if (rsp_tdata[5:2] !== want.rid)
                  report_mismatch("result_id", 64'(rsp_tdata[5:2]), 64'(want.rid));
               if (rsp_tdata[69:6] !== want.wait_ms)
                  report_mismatch("wait_ms", rsp_tdata[69:6], want.wait_ms);
               if (rsp_tdata[70] !== want.pend)
                  report_mismatch("timers_pending", 64'(rsp_tdata[70]), 64'(want.pend));
               if (rsp_tdata[71] !== want.notify)
                  report_mismatch("front_notify", 64'(rsp_tdata[71]), 64'(want.notify));
               if (rsp_tuser !== want.expv)
                  report_mismatch("expired_valid", 64'(rsp_tuser), 64'(want.expv));
               if (rsp_tlast !== want.last)
                  report_mismatch("last", 64'(rsp_tlast), 64'(want.last));
            end
         end
      end
   end

   // Safety net against a hung block.
   initial begin
      #3000000;
      $display("testbench: done, errors");
      $finish;
   end

   // ---- Stimulus -------------------------------------------------------------------------

   logic [63:0] clock_ms = 64'd1000;

   function automatic timer_op_type make_op(input logic [2:0] op, input logic [63:0] now,
                                            input logic [3:0] id, input logic [31:0] period,
                                            input logic rec, input logic fnow);
      timer_op_type t;
      t = '{op, now, id, period, rec, fnow};
      return t;
   endfunction

   function automatic logic [31:0] pick_period();
      case ($urandom_range(0, 9))
         0:       return 32'hFFFF_FFFF;
         1:       return $urandom();
         2:       return 32'd0;
         default: return $urandom_range(1, 3000);
      endcase
   endfunction

   // Mostly a forward-moving clock; sometimes small or large steps back, or a wild value.
   function automatic logic [63:0] pick_now();
      case ($urandom_range(0, 19))
         0:       clock_ms = {$urandom(), $urandom()};
         1:       clock_ms = clock_ms - 64'($urandom_range(1, 5000));
         2:       clock_ms = clock_ms - 64'($urandom()) - 64'd4000000;
         default: clock_ms = clock_ms + 64'($urandom_range(0, 1500));
      endcase
      return clock_ms;
   endfunction

   function automatic timer_op_type random_op();
      int          w;
      logic [2:0]  op;
      w = $urandom_range(0, 99);
      if (w < 25)      op = OP_ADD;
      else if (w < 35) op = OP_CANCEL;
      else if (w < 45) op = OP_REFRESH;
      else if (w < 60) op = OP_RESET;
      else if (w < 80) op = OP_COLLECT;
      else if (w < 96) op = OP_QUERY;
      else if (w < 98) op = OP_SPARE_LO;
      else             op = OP_SPARE_HI;
      return make_op(op, pick_now(), 4'($urandom_range(0, 15)), pick_period(),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endfunction

   task automatic wait_drained();
      while (op_backlog.size() > 0 || ops_taken != ops_issued || rsp_owed.size() > 0)
         @(posedge clock);
      // Let the block finish any sweep that still trails its last response beat.
      repeat (60) @(posedge clock);
   endtask

   task automatic write_window(input logic [31:0] value);
      @(negedge clock);
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tbl_window = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [31:0] windows [4];
      foreach (tbl_armed[i]) begin
         tbl_armed[i]    = 1'b0;
         tbl_rec[i]      = 1'b0;
         tbl_period[i]   = 32'd0;
         tbl_deadline[i] = 64'd0;
      end
      tbl_tickled      = 1'b0;
      tbl_last_collect = 64'd0;
      tbl_window       = RolloverReset;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      windows[0] = RolloverReset;
      windows[1] = 32'd0;
      windows[2] = 32'hFFFF_FFFF;
      windows[3] = $urandom_range(1000, 10000000);

      // Directed part: empty table, fill to full with extreme times and periods, overflow,
      // refused operations, spare codes, a clock rollover and a query.
      write_window(windows[0]);
      enqueue_op(make_op(OP_QUERY,   64'd0, 4'd0, 32'd0, 1'b0, 1'b0));
      enqueue_op(make_op(OP_COLLECT, 64'd5, 4'd0, 32'd0, 1'b0, 1'b0));
      enqueue_op(make_op(OP_RESET,   64'd5, 4'd2, 32'd9, 1'b0, 1'b1));
      for (int i = 0; i < NSLOTS; i++) begin
         case (i % 4)
            0: enqueue_op(make_op(OP_ADD, 64'd1000 + 64'(i), 4'd0,
                                  32'(i * 100), 1'(i[2]), 1'b0));
            1: enqueue_op(make_op(OP_ADD, 64'hFFFF_FFFF_FFFF_FFF0, 4'd0,
                                  32'hFFFF_FFFF, 1'b1, 1'b0));
            2: enqueue_op(make_op(OP_ADD, 64'd1000, 4'd0, 32'd0, 1'b0, 1'b0));
            default: enqueue_op(make_op(OP_ADD, 64'd2000, 4'd0, 32'd50, 1'b1, 1'b0));
         endcase
      end
      enqueue_op(make_op(OP_ADD,     64'd3000, 4'd0,  32'd1,  1'b1, 1'b0));
      enqueue_op(make_op(OP_CANCEL,  64'd3000, 4'd15, 32'd0,  1'b0, 1'b0));
      enqueue_op(make_op(OP_CANCEL,  64'd3000, 4'd15, 32'd0,  1'b0, 1'b0));
      enqueue_op(make_op(OP_REFRESH, 64'd3000, 4'd15, 32'd0,  1'b0, 1'b0));
      enqueue_op(make_op(OP_RESET,   64'd3000, 4'd15, 32'd77, 1'b1, 1'b0));
      enqueue_op(make_op(OP_RESET,   64'd3000, 4'd2,  32'd0,  1'b0, 1'b0));
      enqueue_op(make_op(OP_RESET,   64'd3000, 4'd2,  32'd3,  1'b0, 1'b0));
      enqueue_op(make_op(OP_SPARE_LO, 64'd3000, 4'd0, 32'd0,  1'b0, 1'b0));
      enqueue_op(make_op(OP_SPARE_HI, 64'd3000, 4'd0, 32'd0,  1'b0, 1'b0));
      enqueue_op(make_op(OP_QUERY,   64'd3000, 4'd0,  32'd0,  1'b0, 1'b0));
      enqueue_op(make_op(OP_COLLECT, 64'd9000000, 4'd0, 32'd0, 1'b0, 1'b0));
      enqueue_op(make_op(OP_COLLECT, 64'd10,  4'd0,   32'd0,  1'b0, 1'b0));
      enqueue_op(make_op(OP_REFRESH, 64'd20,  4'd1,   32'd0,  1'b0, 1'b0));
      enqueue_op(make_op(OP_QUERY,   64'd20,  4'd0,   32'd0,  1'b0, 1'b0));
      // Every slot has been written by now, so any reset request is legal from here on.

      // Random part in four window settings. Each phase stops halfway and waits for every
      // response before it sends the rest; the final phase runs with no idling at all.
      for (int ph = 0; ph < 4; ph++) begin
         if (ph > 0) begin
            wait_drained();
            write_window(windows[ph]);
         end
         quiet_bus = (ph == 3);
         clock_ms  = 64'($urandom_range(0, 100000));
         repeat (38) enqueue_op(random_op());
         wait_drained();
         repeat (37) enqueue_op(random_op());
      end
      wait_drained();

      $display("covered %0d requests over four rollover windows (default, 0, max, random)",
               ops_taken);
      $display("checked %0d response beats, %0d of them expiries", rsp_seen, expiries);
      if (error_count == 0 && rsp_owed.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
